// ----- src/kht_pkg.sv -----
`default_nettype none

package kht_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int RESULT_CAP = 4;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int KEY_W      = 16;
  localparam int TIME_W     = 32;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_LONG = 2'd2
  } ev_e;

  typedef enum logic [2:0] {
    OP_SEARCH = 3'd0,
    OP_CLAIM  = 3'd1,
    OP_UP     = 3'd2,
    OP_TICK   = 3'd3,
    OP_ABORT  = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_HOLD = 3'd0,
    REG_KEY_A        = 3'd1,
    REG_HOLD_A       = 3'd2,
    REG_KEY_B        = 3'd3,
    REG_HOLD_B       = 3'd4
  } reg_e;

  // Token that walks the slot chain, one cell per cycle while the output register is not stalled
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              found;
    logic              aborted;
    logic              claimed;
    logic [CNT_W-1:0]  count;
  } tok_t;

  typedef struct packed {
    logic [HOLD_W-1:0] default_hold;
    logic [KEY_W-1:0]  key_a;
    logic [HOLD_W-1:0] hold_a;
    logic [KEY_W-1:0]  key_b;
    logic [HOLD_W-1:0] hold_b;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/kht_cell.sv -----
`default_nettype none

module kht_cell import kht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire cfg_t             cfg_i,
  input  wire tok_t             tok_i,
  output tok_t                  tok_o,
  output logic                  res_valid_o,
  output logic [KEY_W-1:0]      res_key_o
);

  logic [KEY_W-1:0]  key_q, key_d;
  logic [TIME_W-1:0] time_q;
  logic              emitted_q, emitted_d;
  logic              aborted_q, aborted_d;
  logic              stamp;
  tok_t              tok_q, tok_d;

  logic              occupied;
  logic              match;
  logic [HOLD_W-1:0] limit;
  logic [TIME_W-1:0] held;
  logic              long_hit;

  assign occupied = (key_q != '0);
  assign match    = (key_q == tok_i.key);
  assign held     = tok_i.now - time_q;

  always_comb begin
    if (cfg_i.key_a != '0 && cfg_i.key_a == key_q) begin
      limit = cfg_i.hold_a;
    end else if (cfg_i.key_b != '0 && cfg_i.key_b == key_q) begin
      limit = cfg_i.hold_b;
    end else begin
      limit = cfg_i.default_hold;
    end
  end

  assign long_hit = tok_i.valid && (tok_i.op == OP_TICK) && occupied && !emitted_q &&
                    !aborted_q && (held >= {{(TIME_W-HOLD_W){1'b0}}, limit}) &&
                    (tok_i.count < CNT_W'(RESULT_CAP));

  always_comb begin
    tok_d     = tok_i;
    key_d     = key_q;
    emitted_d = emitted_q;
    aborted_d = aborted_q;
    stamp     = 1'b0;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_SEARCH: begin
          if (match) begin
            tok_d.found   = 1'b1;
            tok_d.aborted = aborted_q;
          end
        end
        OP_CLAIM: begin
          // take the first free slot only
          if (!occupied && !tok_i.claimed) begin
            tok_d.claimed = 1'b1;
            key_d         = tok_i.key;
            emitted_d     = 1'b0;
            aborted_d     = 1'b0;
            stamp         = 1'b1;
          end
        end
        OP_UP: begin
          if (match) begin
            tok_d.found   = 1'b1;
            tok_d.aborted = aborted_q;
            key_d         = '0;
            emitted_d     = 1'b0;
            aborted_d     = 1'b0;
          end
        end
        OP_TICK: begin
          if (long_hit) begin
            emitted_d   = 1'b1;
            tok_d.count = tok_i.count + CNT_W'(1);
          end
        end
        OP_ABORT: begin
          if (occupied) begin
            aborted_d = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      key_q     <= '0;
      emitted_q <= 1'b0;
      aborted_q <= 1'b0;
    end else if (en_i) begin
      tok_q     <= tok_d;
      key_q     <= key_d;
      emitted_q <= emitted_d;
      aborted_q <= aborted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && stamp) begin
      time_q <= tok_i.now;
    end
  end

  assign tok_o       = tok_q;
  assign res_valid_o = long_hit;
  assign res_key_o   = key_q;

endmodule

`default_nettype wire

// ----- src/key_hold_tracker.sv -----
// Key hold tracker: keeps held keys in a chain of slot cells and reports
// key-down, key-up and long-press results.
// Input channel (in_valid_i / in_stall_o): one transaction per key event,
// timer tick or abort-all. A new transaction is taken only when the previous
// one has finished; down or up events with key code 0 are taken and dropped.
// Output channel (out_valid_o / out_stall_i): zero to four result
// transactions per input, last_o marks the final one.
// A token walks the row of SLOT_COUNT cells, one cell per cycle while the output
// register is not stalled. It passes from inj_q through every cell register
// before the walk ends and the result register may load; key up, tick, abort and
// a down of a tracked key take one pass, a down of a new key two (a search pass,
// then a claim pass). The next transaction can be taken in the cycle after the
// walk ends; a dropped key-0 event never starts a walk.
// Each tick result waits in a pending register until the next hit or the end
// of the walk, so last_o is known when it leaves.
// A stalled output register holds the whole chain until it drains.
// Reset frees all slots, clears the flags and loads the default thresholds.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i while
// no transaction is in flight; the block does not enforce it. Unused indexes are ignored.
`default_nettype none

module key_hold_tracker import kht_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [KEY_W-1:0]      key_code_i,
  input  wire logic [TIME_W-1:0]     now_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 event_kind_o,
  output logic [KEY_W-1:0]           event_key_o,
  output logic                       table_full_o,
  output logic                       last_o
);

  cfg_t cfg_q;

  tok_t                 tok [SLOT_COUNT+1];
  logic [SLOT_COUNT:0]  tok_vld;
  logic [SLOT_COUNT-1:0] res_v;
  logic [KEY_W-1:0]     res_key [SLOT_COUNT];

  tok_t inj_q;
  logic busy_q;

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [KEY_W-1:0] out_key_q;
  logic             out_full_q;
  logic             out_last_q;

  logic             pend_v_q;
  logic [KEY_W-1:0] pend_key_q;

  logic             en;
  logic             in_acc;
  logic             launch_live;
  tok_t             launch_tok;
  tok_t             tail;
  logic             tail_fire;
  logic             restart;
  tok_t             claim_tok;
  logic             cell_hit;
  logic [KEY_W-1:0] hit_key;
  logic             direct_v;
  logic [1:0]       direct_kind;
  logic             direct_full;
  logic             out_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_hold <= HOLD_W'(1000);
      cfg_q.key_a        <= '0;
      cfg_q.hold_a       <= HOLD_W'(1000);
      cfg_q.key_b        <= '0;
      cfg_q.hold_b       <= HOLD_W'(1000);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_DEFAULT_HOLD: cfg_q.default_hold <= cfg_data_i;
        REG_KEY_A:        cfg_q.key_a        <= cfg_data_i;
        REG_HOLD_A:       cfg_q.hold_a       <= cfg_data_i;
        REG_KEY_B:        cfg_q.key_b        <= cfg_data_i;
        REG_HOLD_B:       cfg_q.hold_b       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The chain moves only when the output register can take a result
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign tail        = tok[SLOT_COUNT];
  assign tail_fire   = en && tail.valid;

  always_comb begin
    launch_tok       = '0;
    launch_tok.key   = key_code_i;
    launch_tok.now   = now_ms_i;
    launch_live      = 1'b1;
    case (kind_e'(kind_i))
      KIND_DOWN: begin
        launch_tok.op = OP_SEARCH;
        launch_live   = (key_code_i != '0);
      end
      KIND_UP: begin
        launch_tok.op = OP_UP;
        launch_live   = (key_code_i != '0);
      end
      KIND_TICK:  launch_tok.op = OP_TICK;
      KIND_ABORT: launch_tok.op = OP_ABORT;
      default:    launch_tok.op = OP_ABORT;
    endcase
    launch_tok.valid = launch_live;
  end

  always_comb begin
    claim_tok         = tail;
    claim_tok.op      = OP_CLAIM;
    claim_tok.found   = 1'b0;
    claim_tok.aborted = 1'b0;
    claim_tok.claimed = 1'b0;
    claim_tok.count   = '0;
  end

  assign tok[0] = inj_q;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    kht_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .cfg_i       (cfg_q),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1]),
      .res_valid_o (res_v[i]),
      .res_key_o   (res_key[i])
    );
  end

  for (genvar i = 0; i <= SLOT_COUNT; i++) begin : g_vld
    assign tok_vld[i] = tok[i].valid;
  end

  always_comb begin
    hit_key = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (res_v[i]) begin
        hit_key = hit_key | res_key[i];
      end
    end
  end
  assign cell_hit = en && (res_v != '0);

  // Outcome when the token leaves the end of the chain
  always_comb begin
    direct_v    = 1'b0;
    direct_kind = EV_DOWN;
    direct_full = 1'b0;
    restart     = 1'b0;
    case (tail.op)
      OP_SEARCH: begin
        restart  = !tail.found;
        direct_v = tail.found && !tail.aborted;
      end
      OP_CLAIM: begin
        direct_v    = 1'b1;
        direct_full = !tail.claimed;
      end
      OP_UP: begin
        direct_v    = !tail.found || !tail.aborted;
        direct_kind = EV_UP;
      end
      default: begin
        direct_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (in_acc) begin
        inj_q  <= launch_tok;
        busy_q <= launch_live;
      end else if (en) begin
        inj_q <= (tail_fire && restart) ? claim_tok : '0;
        if (tail_fire && !restart) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign out_load = (cell_hit && pend_v_q) ||
                    (tail_fire && !restart && ((tail.op == OP_TICK) ? pend_v_q : direct_v));

  // Tick results wait in a pending register until the next hit or the end of the walk so last_o is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cell_hit) begin
        pend_v_q <= 1'b1;
      end else if (tail_fire && !restart && tail.op == OP_TICK) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_hit) begin
      pend_key_q <= hit_key;
      if (pend_v_q) begin
        out_kind_q <= EV_LONG;
        out_key_q  <= pend_key_q;
        out_full_q <= 1'b0;
        out_last_q <= 1'b0;
      end
    end else if (tail_fire && !restart) begin
      if (tail.op == OP_TICK) begin
        out_kind_q <= EV_LONG;
        out_key_q  <= pend_key_q;
        out_full_q <= 1'b0;
        out_last_q <= 1'b1;
      end else begin
        out_kind_q <= direct_kind;
        out_key_q  <= tail.key;
        out_full_q <= direct_full;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_key_o  = out_key_q;
  assign table_full_o = out_full_q;
  assign last_o       = out_last_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the slot chain");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (tok_vld == '0))
    else $error("token in chain while idle");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> busy_q)
    else $error("pending result outside a transaction");

  a_restart_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_fire && restart) |=> (inj_q.valid && inj_q.op == OP_CLAIM && busy_q))
    else $error("claim pass not launched after failed search");

endmodule

`default_nettype wire
